// File: src/dssa_pkg.sv
// ----------------------------------------------------------------------------
// dssa_pkg: shared definitions for the dual stack block
// Request codes, result status codes, register constants and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package dssa_pkg;

	localparam int CAP_W = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [2:0] {
		ACT_PUSH_ONE = 3'd0,
		ACT_PUSH_TWO = 3'd1,
		ACT_POP_ONE  = 3'd2,
		ACT_POP_TWO  = 3'd3,
		ACT_PEEK_ONE = 3'd4,
		ACT_PEEK_TWO = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// take: execute the request on the input port this cycle
	typedef struct packed {
		logic take;
	} ctl_cmd_t;

endpackage

// File: src/dssa_req_if.sv
// ----------------------------------------------------------------------------
// dssa_req_if: request channel
// Valid/ready channel carrying one stack request.
// ----------------------------------------------------------------------------
interface dssa_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   action;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

// File: src/dssa_rsp_if.sv
// ----------------------------------------------------------------------------
// dssa_rsp_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface dssa_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] data;
	logic [1:0]                   status;
	logic                         first_empty;
	logic                         second_empty;

	modport source (output valid, output data, output status, output first_empty,
		output second_empty, input ready);
	modport sink   (input valid, input data, input status, input first_empty,
		input second_empty, output ready);
endinterface

// File: src/dssa_ctrl.sv
// ----------------------------------------------------------------------------
// dssa_ctrl: request sequencer
// Takes one request, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module dssa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dssa_pkg::ctl_cmd_t cmd
);
	import dssa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign cmd.take  = req_ready && req_valid;

endmodule

// File: src/dssa_dp.sv
// ----------------------------------------------------------------------------
// dssa_dp: stack datapath
// Slot memory, the two element counts, the capacity register and the
// result registers.
// ----------------------------------------------------------------------------
module dssa_dp #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dssa_pkg::ctl_cmd_t            cmd,
	input  logic [2:0]                    req_action,
	input  logic signed [DATA_WIDTH-1:0]  req_value,
	input  logic                          cfg_we,
	input  logic [dssa_pkg::CAP_W-1:0]    cfg_data,
	output logic signed [DATA_WIDTH-1:0]  rsp_data,
	output logic [1:0]                    rsp_status,
	output logic                          rsp_first_empty,
	output logic                          rsp_second_empty
);
	import dssa_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = (DEPTH > 511) ? CAP_W : $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] first_q;
	logic [CNT_W-1:0] second_q;
	logic [CNT_W-1:0] first_d;
	logic [CNT_W-1:0] second_d;
	logic [CNT_W-1:0] live_cap;
	logic [CNT_W:0]   fill;
	logic             full;

	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    mem_addr;
	status_t          status_d;

	logic             peek_ok_q;
	status_t          status_q;
	logic             first_empty_q;
	logic             second_empty_q;

	// clamp the register to the slots that exist
	assign live_cap = (32'(cap_q) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
	assign fill     = {1'b0, first_q} + {1'b0, second_q};
	assign full     = fill >= {1'b0, live_cap};

	always_comb begin
		first_d  = first_q;
		second_d = second_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = '0;
		status_d = ST_DONE;
		case (req_action)
			ACT_PUSH_ONE: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = AW'(first_q);
					first_d  = first_q + 1'b1;
				end
			end
			ACT_PUSH_TWO: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = AW'(live_cap - 1'b1 - second_q);
					second_d = second_q + 1'b1;
				end
			end
			ACT_POP_ONE: begin
				if (first_q == '0) status_d = ST_EMPTY;
				else first_d = first_q - 1'b1;
			end
			ACT_POP_TWO: begin
				if (second_q == '0) status_d = ST_EMPTY;
				else second_d = second_q - 1'b1;
			end
			ACT_PEEK_ONE: begin
				if (first_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					mem_addr = AW'(first_q - 1'b1);
				end
			end
			ACT_PEEK_TWO: begin
				if (second_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					mem_addr = AW'(live_cap - second_q);
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mem_we) mem[mem_addr] <= req_value;
		if (cmd.take && mem_re) rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			first_q  <= '0;
			second_q <= '0;
		end else if (cfg_we) begin
			cap_q    <= cfg_data;
			first_q  <= '0;
			second_q <= '0;
		end else if (cmd.take) begin
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			peek_ok_q      <= mem_re;
			status_q       <= status_d;
			first_empty_q  <= (first_d == '0);
			second_empty_q <= (second_d == '0);
		end
	end

	assign rsp_data         = peek_ok_q ? rd_q : '0;
	assign rsp_status       = status_q;
	assign rsp_first_empty  = first_empty_q;
	assign rsp_second_empty = second_empty_q;

endmodule

// File: src/dual_stack_shared_array.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_array: two LIFO stacks in one slot memory
// Stack one grows up from slot 0, stack two grows down from the top slot
// in use. Each request pushes, pops or peeks one stack and returns one
// result with a status and both empty flags.
// ----------------------------------------------------------------------------
//
//  channel | role   | moves
//  --------+--------+----------------------------------------------
//  req     | sink   | one request: action, value
//  rsp     | source | one result: data, status, first/second empty
//  cfg     | write  | capacity register, no read-back
//
//  The acceptance edge does the count update and at most one memory
//  access, and the next cycle presents the registered result. A new
//  request enters only once the result register has drained.
//  A stalled result holds until rsp.ready; req.ready stays low meanwhile.
//  Reset empties both stacks and loads capacity 256; slot contents are
//  left as they are. A capacity write empties both stacks too.
// ----------------------------------------------------------------------------
module dual_stack_shared_array #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dssa_req_if.sink                   req,
	dssa_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [dssa_pkg::CAP_W-1:0] cfg_data
);
	import dssa_pkg::*;

	ctl_cmd_t cmd;

	// sequencer: accept a request, hold the result until taken
	dssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: counts, slot memory, capacity and result registers
	dssa_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.req_action       (req.action),
		.req_value        (req.value),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.rsp_data         (rsp.data),
		.rsp_status       (rsp.status),
		.rsp_first_empty  (rsp.first_empty),
		.rsp_second_empty (rsp.second_empty)
	);

endmodule
